@@ src/cd_read_jitter_overlap_match_core_defines.svh @@
// Assertion macros shared by the checker.
`ifndef CD_READ_JITTER_OVERLAP_MATCH_CORE_DEFINES_SVH
`define CD_READ_JITTER_OVERLAP_MATCH_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define CDJ_ASSERT_IMP(label, clk, rstn, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("assertion failed");
// Implication whose consequence is checked in the following cycle.
`define CDJ_ASSERT_NEXT(label, clk, rstn, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

@@ src/cdj_pkg.sv @@
package cdj_pkg;
  localparam int unsigned WordsPerSector = 588;

  typedef enum logic [1:0] {
    OP_LOAD_PREV = 2'd0,
    OP_LOAD_CUR  = 2'd1,
    OP_SEARCH    = 2'd2,
    OP_SWAP      = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_MATCH   = 2'd0,
    ST_SILENCE = 2'd1,
    ST_NOMATCH = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_SECTORS = 2'd0,
    CFG_OVERLAP = 2'd1,
    CFG_KEY     = 2'd2,
    CFG_OFFSETS = 2'd3
  } cfg_e;

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_SIL_RD, S_SIL_WAIT, S_SIL_CMP,
    S_KEY_INIT, S_KEY_RD, S_KEY_WAIT, S_KEY_CMP, S_NEXT, S_DONE
  } fsm_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [13:0] word_index;
    logic [31:0] data_word;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] byte_offset;
  } rsp_t;

  // Memory access request from the sequencer to the buffer pair.
  typedef struct packed {
    logic        rd;
    logic [13:0] prev_addr;
    logic [13:0] cur_addr;
  } mem_rd_t;
endpackage

@@ src/cdj_buffers.sv @@
module cdj_buffers #(
  parameter int unsigned Depth = 9408,
  parameter int unsigned AW = 14
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic              we_bank_b_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [31:0]       wdata_i,
  input  logic              prev_is_b_i,
  input  cdj_pkg::mem_rd_t  rd_i,
  output logic [31:0]       prev_o,
  output logic [31:0]       cur_o
);
  import cdj_pkg::*;

  logic [31:0] bank_a [Depth];
  logic [31:0] bank_b [Depth];
  logic [31:0] a_q, b_q;
  logic [AW-1:0] a_ad, b_ad;

  // Previous bank reads at prev_addr, current bank at cur_addr.
  assign a_ad = prev_is_b_i ? rd_i.cur_addr[AW-1:0] : rd_i.prev_addr[AW-1:0];
  assign b_ad = prev_is_b_i ? rd_i.prev_addr[AW-1:0] : rd_i.cur_addr[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (we_i && !we_bank_b_i) bank_a[waddr_i] <= wdata_i;
    if (rd_i.rd) a_q <= bank_a[a_ad];
  end

  always_ff @(posedge clk_i) begin
    if (we_i && we_bank_b_i) bank_b[waddr_i] <= wdata_i;
    if (rd_i.rd) b_q <= bank_b[b_ad];
  end

  assign prev_o = prev_is_b_i ? b_q : a_q;
  assign cur_o  = prev_is_b_i ? a_q : b_q;
endmodule

@@ src/cd_read_jitter_overlap_match_core.sv @@
// Overlap jitter correction engine for audio disc reads.
// Requests arrive on req_valid_i/req_ready_o with a req_t payload. A load
// request writes one word into the previous or the current buffer when its
// index lies inside the buffers. A swap request exchanges the roles of the
// two buffers. Neither produces a response.
// A search request produces one response on rsp_valid_o/rsp_ready_i. It first
// walks back through the previous buffer comparing neighboring words, for up
// to overlap*588 steps. It then tries each key start offset against up to
// 588*(1+overlap) positions, comparing one key word at a time and taking a
// separate step to move on after a miss.
// The block is busy (req_ready_o low) from acceptance of a search until its
// response is taken; if the receiver stalls, the response register holds.
// Configuration writes via cfg_we_i take effect at the next search.
// Reset clears the buffer role flag, the registers to their defaults and the
// control state; buffer contents are undefined until written.
module cd_read_jitter_overlap_match_core #(
  parameter int unsigned MaxSectors = 16,
  parameter int unsigned MaxKeyBytes = 400
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  cdj_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output cdj_pkg::rsp_t rsp_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [8:0]    cfg_data_i
);
  import cdj_pkg::*;

  localparam int unsigned Depth = MaxSectors * WordsPerSector;
  localparam int unsigned AW = $clog2(Depth + 1);
  localparam logic [4:0] MaxS = 5'(MaxSectors > 16 ? 16 : MaxSectors);
  localparam logic [8:0] MaxL = 9'(MaxKeyBytes);

  logic [4:0] sec_q;
  logic [3:0] ovl_q;
  logic [8:0] key_q, ofs_q;
  logic       prev_b_q;
  fsm_e       st_q, st_d;

  // Clamped search parameters, captured at start.
  logic [4:0]  s_q;
  logic [3:0]  v_q;
  logic [6:0]  whole_q;
  logic [1:0]  rest_q;
  logic [8:0]  ofs_lim_q;
  logic [13:0] words_q;
  logic [13:0] lim_q;   // step limit of the current phase
  logic [13:0] n_q;     // steps taken
  logic [13:0] idx_q;   // silence index / search position
  logic [8:0]  k_q;
  logic [6:0]  i_q;     // key word index
  rsp_t        rsp_q;
  logic        rsp_v_q;

  logic [4:0] s_c;
  logic [3:0] v_c, vmax;
  logic [8:0] l_c, o_c;
  always_comb begin
    s_c = sec_q < 5'd4 ? 5'd4 : (sec_q > MaxS ? MaxS : sec_q);
    vmax = 4'(s_c - 5'd2);
    v_c = ovl_q < 4'd1 ? 4'd1 : (ovl_q > vmax ? vmax : ovl_q);
    l_c = key_q < 9'd4 ? 9'd4 : (key_q > MaxL ? MaxL : key_q);
    o_c = ofs_q < 9'd1 ? 9'd1 : (ofs_q > 9'd256 ? 9'd256 : ofs_q);
  end

  mem_rd_t     rd;
  logic [31:0] prev_w, cur_w, hold_q;
  logic        acc, is_last;
  logic [31:0] mask;

  assign acc = req_valid_i && req_ready_o;
  assign req_ready_o = (st_q == S_IDLE);

  cdj_buffers #(.Depth(Depth), .AW(AW)) u_buf (
    .clk_i, .we_i(acc && (req_i.opcode == OP_LOAD_PREV || req_i.opcode == OP_LOAD_CUR)
                  && (32'(req_i.word_index) < 32'(Depth))),
    .we_bank_b_i(prev_b_q ^ (req_i.opcode == OP_LOAD_CUR)),
    .waddr_i(AW'(req_i.word_index)), .wdata_i(req_i.data_word),
    .prev_is_b_i(prev_b_q), .rd_i(rd), .prev_o(prev_w), .cur_o(cur_w)
  );

  assign is_last = (i_q == whole_q);
  always_comb begin
    unique case (rest_q)
      2'd1:    mask = 32'h0000_00ff;
      2'd2:    mask = 32'h0000_ffff;
      2'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'h0;
    endcase
  end

  always_comb begin
    st_d = st_q;
    rd = '0;
    unique case (st_q)
      S_IDLE:     if (acc && req_i.opcode == OP_SEARCH) st_d = S_SETUP;
      S_SETUP:    st_d = (lim_q == 14'd0) ? S_DONE : S_SIL_RD;
      S_SIL_RD: begin
        rd.rd = 1'b1; rd.prev_addr = idx_q; rd.cur_addr = '0; st_d = S_SIL_WAIT;
      end
      S_SIL_WAIT: begin
        rd.rd = 1'b1; rd.prev_addr = idx_q - 14'd1; st_d = S_SIL_CMP;
      end
      S_SIL_CMP: begin
        if (hold_q != prev_w) st_d = S_KEY_INIT;
        else if (n_q + 14'd1 >= lim_q) st_d = S_DONE;
        else st_d = S_SIL_RD;
      end
      S_KEY_INIT: st_d = S_KEY_RD;
      S_KEY_RD: begin
        rd.rd = 1'b1;
        rd.prev_addr = idx_q + 14'(i_q);
        rd.cur_addr = 14'(k_q) + 14'(i_q);
        st_d = S_KEY_WAIT;
      end
      S_KEY_WAIT: st_d = S_KEY_CMP;
      S_KEY_CMP: begin
        if (!is_last) begin
          st_d = (prev_w == cur_w) ? S_KEY_RD : S_NEXT;
        end else if (rest_q == 2'd0 || ((prev_w ^ cur_w) & mask) == 32'h0) begin
          st_d = S_DONE;
        end else begin
          st_d = S_NEXT;
        end
      end
      // The last position of the last start offset ends the search.
      S_NEXT: begin
        st_d = (n_q + 14'd1 >= lim_q && k_q == ofs_lim_q) ? S_DONE : S_KEY_RD;
      end
      S_DONE: if (rsp_v_q && rsp_ready_i) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  logic key_ok;
  assign key_ok = is_last && (rest_q == 2'd0 || ((prev_w ^ cur_w) & mask) == 32'h0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; sec_q <= 5'd8; ovl_q <= 4'd3; key_q <= 9'd12; ofs_q <= 9'd12;
      prev_b_q <= 1'b0; rsp_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        unique case (cfg_e'(cfg_index_i))
          CFG_SECTORS: sec_q <= cfg_data_i[4:0];
          CFG_OVERLAP: ovl_q <= cfg_data_i[3:0];
          CFG_KEY:     key_q <= cfg_data_i;
          CFG_OFFSETS: ofs_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (acc && req_i.opcode == OP_SWAP) prev_b_q <= ~prev_b_q;
      // The response becomes valid as the sequencer enters the done state
      // and stays valid until it is taken.
      if (st_q != S_DONE && st_d == S_DONE) rsp_v_q <= 1'b1;
      else if (rsp_v_q && rsp_ready_i) rsp_v_q <= 1'b0;
    end
  end

  logic [13:0] words_c;
  logic [15:0] sil_off;
  assign words_c = 14'(s_c) * 14'(WordsPerSector);
  assign sil_off = 16'(16'(s_q - 5'(v_q)) * 16'(WordsPerSector * 4) + 16'd4);

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      S_IDLE: begin
        s_q <= s_c; v_q <= v_c; whole_q <= l_c[8:2]; rest_q <= l_c[1:0];
        ofs_lim_q <= o_c; words_q <= words_c;
        lim_q <= 14'(v_c) * 14'(WordsPerSector);
        idx_q <= words_c - 14'(WordsPerSector) - 14'd1;
        n_q <= '0;
        rsp_q <= {ST_SILENCE, 16'd0};
      end
      S_SETUP: rsp_q <= {ST_SILENCE, sil_off};
      S_SIL_WAIT: hold_q <= prev_w;
      S_SIL_CMP: begin
        idx_q <= idx_q - 14'd1; n_q <= n_q + 14'd1;
      end
      S_KEY_INIT: begin
        lim_q <= 14'(v_q + 4'd1) * 14'(WordsPerSector);
        n_q <= '0; k_q <= '0; i_q <= '0;
        idx_q <= words_q - 14'(whole_q) - 14'd1;
        rsp_q <= {ST_NOMATCH, 16'd0};
      end
      S_KEY_CMP: begin
        if (key_ok) begin
          rsp_q <= {ST_MATCH, 16'({idx_q, 2'b00}) + 16'd4 - 16'({k_q, 2'b00})};
        end else if (!is_last && prev_w == cur_w) begin
          i_q <= i_q + 7'd1;
        end
      end
      S_NEXT: begin
        i_q <= '0;
        if (n_q + 14'd1 >= lim_q) begin
          n_q <= '0; idx_q <= words_q - 14'(whole_q) - 14'd1;
          k_q <= k_q + 9'd1;
        end else begin
          n_q <= n_q + 14'd1; idx_q <= idx_q - 14'd1;
        end
      end
      default: ;
    endcase
  end

  assign rsp_valid_o = rsp_v_q;
  assign rsp_o = rsp_q;
endmodule

@@ src/cdj_checker.sv @@
`include "cd_read_jitter_overlap_match_core_defines.svh"
module cdj_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          req_valid_i,
  input logic          req_ready_o,
  input cdj_pkg::req_t req_i,
  input logic          rsp_valid_o,
  input logic          rsp_ready_i,
  input cdj_pkg::rsp_t rsp_o
);
  import cdj_pkg::*;
  `CDJ_ASSERT_IMP(a_busy_while_rsp, clk_i, rst_ni, rsp_valid_o, !req_ready_o)
  `CDJ_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_o && !rsp_ready_i,
    rsp_valid_o && $stable(rsp_o))
  `CDJ_ASSERT_NEXT(a_search_busy, clk_i, rst_ni,
    req_valid_i && req_ready_o && req_i.opcode == OP_SEARCH, !req_ready_o)
  `CDJ_ASSERT_IMP(a_status_legal, clk_i, rst_ni, rsp_valid_o,
    rsp_o.status != 2'd3)
endmodule

bind cd_read_jitter_overlap_match_core cdj_checker u_chk (
  .clk_i, .rst_ni, .req_valid_i, .req_ready_o, .req_i,
  .rsp_valid_o, .rsp_ready_i, .rsp_o
);

@@ tb/match_scoreboard.sv @@
`timescale 1ns / 1ps

// Scoreboard for the overlap match core: keeps its own copy of both buffers,
// the role flag and the registers, and predicts the response of each search.
class match_scoreboard;
  localparam int unsigned Depth = 16 * 588;

  logic [31:0]    bank [2][Depth];
  bit             prev_is_b;
  logic [4:0]     sectors;
  logic [3:0]     overlap;
  logic [8:0]     key_len;
  logic [8:0]     offsets;
  cdj_pkg::rsp_t  expected_q[$];
  int unsigned    errors;

  function new();
    for (int i = 0; i < Depth; i++) begin
      bank[0][i] = '0;
      bank[1][i] = '0;
    end
    prev_is_b = 1'b0;
    sectors   = 5'd8;
    overlap   = 4'd3;
    key_len   = 9'd12;
    offsets   = 9'd12;
    errors    = 0;
  endfunction

  function void write_reg(cdj_pkg::cfg_e idx, logic [8:0] d);
    case (idx)
      cdj_pkg::CFG_SECTORS: sectors = d[4:0];
      cdj_pkg::CFG_OVERLAP: overlap = d[3:0];
      cdj_pkg::CFG_KEY:     key_len = d;
      cdj_pkg::CFG_OFFSETS: offsets = d;
      default: ;
    endcase
  endfunction

  function int unsigned clampu(int unsigned x, int unsigned lo, int unsigned hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  function int unsigned eff_sectors();
    return clampu(sectors, 4, 16);
  endfunction

  function int unsigned eff_overlap();
    return clampu(overlap, 1, eff_sectors() - 2);
  endfunction

  function int unsigned eff_key();
    return clampu(key_len, 4, 400);
  endfunction

  function int unsigned eff_offsets();
    return clampu(offsets, 1, 256);
  endfunction

  // Silence check first, then the key search over every start offset.
  function cdj_pkg::rsp_t search_result();
    cdj_pkg::rsp_t r;
    int unsigned s, v, words, lim, idx, n, whole, rest, ofs, pos;
    int unsigned p, c;
    logic [31:0] mask;
    bit hit;
    s     = eff_sectors();
    v     = eff_overlap();
    ofs   = eff_offsets();
    whole = eff_key() / 4;
    rest  = eff_key() % 4;
    words = s * 588;
    p     = prev_is_b;
    c     = !prev_is_b;
    lim   = 588 * v;
    idx   = words - 589;
    n     = 0;
    while (n < lim && bank[p][idx] === bank[p][idx - 1]) begin
      idx--;
      n++;
    end
    if (n >= lim) begin
      r.status      = cdj_pkg::ST_SILENCE;
      r.byte_offset = 16'((s - v) * 2352 + 4);
      return r;
    end
    mask = (32'd1 << (rest * 8)) - 32'd1;
    lim  = 588 * (1 + v);
    for (int unsigned k = 0; k <= ofs; k++) begin
      for (n = 0; n < lim; n++) begin
        pos = words - whole - 1 - n;
        hit = 1'b1;
        for (int unsigned i = 0; i < whole && hit; i++) begin
          if (bank[p][pos + i] !== bank[c][k + i]) hit = 1'b0;
        end
        if (hit && rest != 0 && ((bank[p][pos + whole] ^ bank[c][k + whole]) & mask) != 0) begin
          hit = 1'b0;
        end
        if (hit) begin
          r.status      = cdj_pkg::ST_MATCH;
          r.byte_offset = 16'(4 * pos + 4 - 4 * k);
          return r;
        end
      end
    end
    r.status      = cdj_pkg::ST_NOMATCH;
    r.byte_offset = '0;
    return r;
  endfunction

  // Applies one accepted request to the shadow state.
  function void note_request(cdj_pkg::req_t q);
    case (cdj_pkg::op_e'(q.opcode))
      cdj_pkg::OP_LOAD_PREV: if (q.word_index < Depth) bank[prev_is_b][q.word_index] = q.data_word;
      cdj_pkg::OP_LOAD_CUR:  if (q.word_index < Depth) bank[!prev_is_b][q.word_index] = q.data_word;
      cdj_pkg::OP_SWAP:      prev_is_b = !prev_is_b;
      default:               expected_q.push_back(search_result());
    endcase
  endfunction

  function void check_response(cdj_pkg::rsp_t got);
    cdj_pkg::rsp_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected response status=%0d offset=%0d", $time, got.status,
               got.byte_offset);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    if (got.status !== want.status) begin
      $display("%0t: status mismatch expected=%0d actual=%0d", $time, want.status,
               got.status);
      errors++;
    end
    if (got.byte_offset !== want.byte_offset) begin
      $display("%0t: byte_offset mismatch expected=%0d actual=%0d", $time,
               want.byte_offset, got.byte_offset);
      errors++;
    end
  endfunction
endclass

@@ tb/tb_cd_read_jitter_overlap_match_core.sv @@
`timescale 1ns / 1ps

module tb_cd_read_jitter_overlap_match_core;
  import cdj_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        req_valid_i;
  logic        req_ready_o;
  req_t        req_i;
  logic        rsp_valid_o;
  logic        rsp_ready_i;
  rsp_t        rsp_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [8:0]  cfg_data_i;

  match_scoreboard sb = new();

  // When set, neither side inserts idle cycles; used for the tail of the run.
  bit          quiet;
  int unsigned stall_left;
  int unsigned sent;

  cd_read_jitter_overlap_match_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Response side: every accepted response is checked against the oldest
  // prediction, and ready is dropped in random bursts unless the run is quiet.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o && rsp_ready_i) begin
      sb.check_response(rsp_o);
    end
    if (stall_left > 0) begin
      stall_left--;
      rsp_ready_i <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 15) - 1;
      rsp_ready_i <= 1'b0;
    end else begin
      rsp_ready_i <= 1'b1;
    end
  end

  // Sends one request and waits until it is accepted; valid stays high from
  // one request to the next unless a random idle burst is inserted first.
  task automatic send(op_e op, int unsigned idx, logic [31:0] d);
    req_t q;
    q.opcode     = op;
    q.word_index = idx[13:0];
    q.data_word  = d;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i       <= q;
    do @(posedge clk_i); while (!req_ready_o);
    sb.note_request(q);
    sent++;
  endtask

  // Holds the sender until every predicted response has been taken, then
  // keeps waiting so that a trailing load or swap has settled too.
  task automatic drain();
    req_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_e idx, logic [8:0] d);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.write_reg(idx, d);
  endtask

  task automatic configure(logic [8:0] s, logic [8:0] v, logic [8:0] l, logic [8:0] o);
    drain();
    cfg_write(CFG_SECTORS, s);
    cfg_write(CFG_OVERLAP, v);
    cfg_write(CFG_KEY, l);
    cfg_write(CFG_OFFSETS, o);
  endtask

  // Ignored loads and a pair of swaps that cancel out; neither changes what
  // the next search sees.
  task automatic noise();
    case ($urandom_range(0, 3))
      0: send(op_e'($urandom_range(0, 1)), $urandom_range(9408, 16383), $urandom());
      1: begin
        send(OP_SWAP, $urandom_range(0, 16383), $urandom());
        send(OP_SWAP, $urandom_range(0, 16383), $urandom());
      end
      default: ;
    endcase
  endtask

  // Writes a key at the head of the current block and plants it gap words
  // below the top of the previous block, so the search hits after gap tries.
  // The two words just below the last sector are made different so that the
  // silence walk stops at once.
  task automatic run_match(int unsigned gap, bit swap_first);
    int unsigned words, whole, base;
    logic [31:0] key[$];
    logic [31:0] w;
    words = sb.eff_sectors() * 588;
    whole = sb.eff_key() / 4;
    base  = words - whole - 1 - gap;
    if (swap_first) send(OP_SWAP, $urandom_range(0, 16383), $urandom());
    for (int unsigned i = 0; i <= whole; i++) begin
      w = $urandom();
      key.push_back(w);
      send(OP_LOAD_CUR, i, w);
      if ($urandom_range(0, 15) == 0) noise();
    end
    w = $urandom();
    send(OP_LOAD_PREV, words - 590, w);
    send(OP_LOAD_PREV, words - 589, ~w);
    for (int unsigned j = base; j < words; j++) begin
      send(OP_LOAD_PREV, j, (j - base <= whole) ? key[j - base] : $urandom());
    end
    noise();
    send(OP_SEARCH, $urandom_range(0, 16383), $urandom());
  endtask

  // Fills the silence window of the previous block with one repeated word.
  task automatic run_silence();
    int unsigned words, lim;
    logic [31:0] w;
    words = sb.eff_sectors() * 588;
    lim   = 588 * sb.eff_overlap();
    w     = $urandom();
    for (int unsigned j = words - 589 - lim; j <= words - 589; j++) begin
      send(OP_LOAD_PREV, j, w);
    end
    send(OP_SEARCH, $urandom_range(0, 16383), $urandom());
  endtask

  // With second_hit, fills the whole search window with random words, so the
  // first start offset misses everywhere, and plants the key of start offset
  // one at the top. Without it, only the top words of a window filled before
  // under the same settings are made random again, so the search ends with
  // no match.
  task automatic run_full_window(bit second_hit);
    int unsigned words, whole, lim, ofs, low;
    logic [31:0] cur_w[$];
    logic [31:0] w;
    words = sb.eff_sectors() * 588;
    whole = sb.eff_key() / 4;
    ofs   = sb.eff_offsets();
    lim   = 588 * (1 + sb.eff_overlap());
    low   = words - whole - lim;
    if (second_hit) begin
      for (int unsigned i = 0; i <= ofs + whole; i++) begin
        w = $urandom();
        cur_w.push_back(w);
        send(OP_LOAD_CUR, i, w);
      end
      for (int unsigned j = low; j < words; j++) begin
        if (j >= words - whole - 1) begin
          send(OP_LOAD_PREV, j, cur_w[1 + j - (words - whole - 1)]);
        end else begin
          send(OP_LOAD_PREV, j, $urandom());
        end
      end
    end else begin
      for (int unsigned j = words - whole - 1; j < words; j++) begin
        send(OP_LOAD_PREV, j, $urandom());
      end
    end
    send(OP_SEARCH, $urandom_range(0, 16383), $urandom());
  endtask

  initial begin
    #50ms;
    $display("tb_cd_read_jitter_overlap_match_core: FAIL");
    $finish;
  end

  initial begin
    rst_ni      <= 1'b0;
    req_valid_i <= 1'b0;
    req_i       <= '0;
    rsp_ready_i <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= CFG_SECTORS;
    cfg_data_i  <= '0;
    quiet       = 1'b0;
    stall_left  = 0;
    sent        = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: reset defaults, then the register extremes, clamping of
    // out-of-range settings, trailing partial key words, silence, a hit at
    // the second start offset and a search that finds nothing.
    run_match(0, 1'b0);
    run_match(2, 1'b1);
    configure(9'd4, 9'd1, 9'd7, 9'd0);
    run_match(1, 1'b0);
    run_silence();
    configure(9'd6, 9'd2, 9'd5, 9'd1);
    run_match(3, 1'b1);
    configure(9'd16, 9'd14, 9'd400, 9'd256);
    run_match(0, 1'b0);
    configure(9'd31, 9'd0, 9'd2, 9'd511);
    run_match(1, 1'b1);
    configure(9'd4, 9'd15, 9'd10, 9'd0);
    run_full_window(1'b1);
    run_full_window(1'b0);

    // Random part: short match sequences with random content under randomly
    // chosen settings, mostly with short keys.
    sent = 0;
    while (sent < 500) begin
      if ($urandom_range(0, 5) == 0) begin
        configure($urandom_range(0, 511), $urandom_range(0, 511),
                  ($urandom_range(0, 7) == 0) ? $urandom_range(0, 511)
                                              : $urandom_range(0, 24),
                  $urandom_range(0, 511));
      end
      if (sent > 420) quiet = 1'b1;
      run_match($urandom_range(0, 3), $urandom_range(0, 1));
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb_cd_read_jitter_overlap_match_core: PASS");
    end else begin
      $display("tb_cd_read_jitter_overlap_match_core: FAIL");
    end
    $finish;
  end
endmodule
